### rtl/core/file_cache_ttl_lru_budget_core_macros.svh
// Assertion macros shared by the cache metadata core RTL.
// No dependencies; define SYNTH to compile the checks away.
`ifndef FILE_CACHE_TTL_LRU_BUDGET_CORE_MACROS_SVH
`define FILE_CACHE_TTL_LRU_BUDGET_CORE_MACROS_SVH
`ifndef SYNTH
`define FC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/core/fcache_pkg.sv
// Shared types, codes and constants of the file cache metadata core.
// No dependencies.
package fcache_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int NOW_W  = 48;
    localparam int EXP_W  = 49;
    localparam int VOL_W  = 5;
    localparam int INO_W  = 64;
    localparam int SIZE_W = 32;
    localparam int TOT_W  = 33;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;

    localparam logic [CFG_W-1:0] TTL_DEF    = 32'd300000;
    localparam logic [CFG_W-1:0] BUDGET_DEF = 32'd25165824;
    localparam logic [CFG_W-1:0] MAXF_DEF   = 32'd4194304;

    localparam logic [CIDX_W-1:0] CFG_TTL    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BUDGET = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAXF   = 2'd2;

    localparam logic [1:0] OC_HIT    = 2'd0;
    localparam logic [1:0] OC_FILL   = 2'd1;
    localparam logic [1:0] OC_BYPASS = 2'd2;
    localparam logic [1:0] OC_INV    = 2'd3;

    localparam logic [1:0] MODE_INV = 2'd0;
    localparam logic [1:0] MODE_EXP = 2'd1;
    localparam logic [1:0] MODE_LRU = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    typedef struct packed {
        logic [VOL_W-1:0]  volume;
        logic [INO_W-1:0]  inode;
        logic [SIZE_W-1:0] size;
        logic [EXP_W-1:0]  expiry;
        logic [NOW_W-1:0]  last_use;
    } t_rec;

    typedef struct packed {
        logic       load_in;
        logic       scan_start;
        logic [1:0] scan_mode;
        logic       hit_write;
        logic       drop_lru;
        logic       fill;
        logic       load_out;
        logic [1:0] out_code;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_full;
        logic cmd_inv;
        logic hit;
        logic cacheable;
        logic fits;
        logic free;
        logic lru;
    } t_sts;

endpackage

### rtl/core/file_cache_ttl_lru_budget_core.sv
// Top level of the whole-file cache metadata core: stream ports, config port.
// Depends on fcache_pkg, fcache_ctrl and fcache_dp.
//
// Metadata engine for a whole-file cache with per-entry lifetime, least-recently-used
// replacement and a byte budget. Each read access (tuser 0) first drops entries whose
// expiry is at or before now_ms, then looks up volume, inode and size; a hit refreshes
// last use and expiry, a cacheable miss evicts LRU entries until the file fits and is
// filled, anything else bypasses. tuser 1 invalidates every slot. One item is in work
// at a time; the slot memory has one read port and every pass over it walks all slots
// one per cycle. An invalidate, a hit or an uncacheable bypass needs one pass, a
// fill a second (LRU) pass and, when every slot is full, a drop step, and each extra
// budget eviction another pass. The next item is taken while a result still waits in
// the output register. Config writes are always accepted and must only happen while the
// core is idle. No clearing pass after reset.
module file_cache_ttl_lru_budget_core
    import fcache_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // now_ms[47:0], volume[52:48], inode[116:53], file_size[148:117],
    // is_plain_file[149], zero[151:150]
    input  logic [151:0]      i_s_axis_tdata,
    // cmd[0]
    input  logic [0:0]        i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // outcome[1:0], slot[5:2], evicted_count[10:6], cached_bytes[42:11], zero[47:43]
    output logic [47:0]       o_m_axis_tdata,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);
    t_cmd             cmd;
    t_sts             sts;
    logic [1:0]       outcome;
    logic [3:0]       slot;
    logic [CNT_W-1:0] evicted;
    logic [31:0]      cached;

    // config registers take a transfer on any cycle
    assign o_cfg_ready = 1'b1;

    fcache_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fcache_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_cmd    (i_s_axis_tuser[0]),
        .i_in_now    (i_s_axis_tdata[47:0]),
        .i_in_vol    (i_s_axis_tdata[52:48]),
        .i_in_ino    (i_s_axis_tdata[116:53]),
        .i_in_size   (i_s_axis_tdata[148:117]),
        .i_in_plain  (i_s_axis_tdata[149]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_idx   (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_outcome   (outcome),
        .o_slot      (slot),
        .o_evicted   (evicted),
        .o_cached    (cached)
    );

    assign o_m_axis_tdata = {5'b0, cached, evicted, slot, outcome};

endmodule

### rtl/core/fcache_dp.sv
// Datapath of the file cache metadata core: slot memory, valid bits, scans, byte total.
// Depends on fcache_pkg and the core macros header.
`include "file_cache_ttl_lru_budget_core_macros.svh"
module fcache_dp
    import fcache_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_cmd,
    input  logic [NOW_W-1:0]  i_in_now,
    input  logic [VOL_W-1:0]  i_in_vol,
    input  logic [INO_W-1:0]  i_in_ino,
    input  logic [SIZE_W-1:0] i_in_size,
    input  logic              i_in_plain,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_outcome,
    output logic [3:0]        o_slot,
    output logic [CNT_W-1:0]  o_evicted,
    output logic [31:0]       o_cached
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST  = IW'(SLOTS - 1);
    localparam logic [CW-1:0] CLAST = CW'(SLOTS - 1);

    logic              r_cmd_inv, r_plain;
    logic [NOW_W-1:0]  r_now;
    logic [VOL_W-1:0]  r_vol;
    logic [INO_W-1:0]  r_ino;
    logic [SIZE_W-1:0] r_size;
    logic [CFG_W-1:0]  r_ttl, r_budget, r_maxf;

    logic [SLOTS-1:0]  r_valid;
    t_rec              r_mem [SLOTS];
    t_rec              r_q;

    logic              r_busy, r_ph, r_done;
    logic [CW-1:0]     r_ctr;
    logic [IW-1:0]     r_ph_idx;
    logic [1:0]        r_mode;

    logic              r_hit, r_lru, r_free;
    logic [IW-1:0]     r_hit_idx, r_lru_idx, r_free_idx;
    logic [NOW_W-1:0]  r_lru_last;
    logic [SIZE_W-1:0] r_lru_size;

    logic [TOT_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_ov;
    logic [1:0]        r_oc;
    logic [3:0]        r_os;
    logic [CNT_W-1:0]  r_oe;
    logic [31:0]       r_ob;

    logic [EXP_W-1:0]  exp_new;
    logic              cur_v, expired, match;
    logic              hit_take, lru_take, free_take;
    logic              drop_en;
    logic [IW-1:0]     drop_idx, tgt, out_idx, rd_idx;
    logic [SIZE_W-1:0] drop_size;
    logic [TOT_W-1:0]  tot_sub;
    logic [TOT_W:0]    need;
    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    t_rec              mem_wd;

    always_comb begin
        exp_new   = {1'b0, r_now} + EXP_W'(r_ttl);
        rd_idx    = r_ctr[IW-1:0];
        cur_v     = r_valid[r_ph_idx];
        expired   = r_q.expiry <= {1'b0, r_now};
        match     = (r_q.volume == r_vol) && (r_q.inode == r_ino) && (r_q.size == r_size);
        hit_take  = r_ph && cur_v && (r_mode == MODE_EXP) && !expired && match && !r_hit;
        lru_take  = r_ph && cur_v && (r_mode == MODE_LRU)
                    && (!r_lru || (r_q.last_use < r_lru_last));
        free_take = r_ph && !cur_v && (r_mode == MODE_LRU) && !r_free;
        drop_en   = (r_ph && cur_v && ((r_mode == MODE_INV) ||
                    ((r_mode == MODE_EXP) && expired))) || i_cmd.drop_lru;
        drop_idx  = i_cmd.drop_lru ? r_lru_idx : r_ph_idx;
        drop_size = i_cmd.drop_lru ? r_lru_size : r_q.size;
        tot_sub   = (r_total >= TOT_W'(drop_size)) ? (r_total - TOT_W'(drop_size)) : '0;
        need      = {1'b0, r_total} + (TOT_W + 1)'(r_size);
        tgt       = r_free ? r_free_idx : (r_lru ? r_lru_idx : '0);
        // slot reported with the result: hit index, fill target or zero
        case (i_cmd.out_code)
            OC_HIT:  out_idx = r_hit_idx;
            OC_FILL: out_idx = tgt;
            default: out_idx = '0;
        endcase
        mem_we    = i_cmd.hit_write || i_cmd.fill;
        mem_wa    = i_cmd.hit_write ? r_hit_idx : tgt;
        mem_wd    = '{volume: r_vol, inode: r_ino, size: r_size,
                      expiry: exp_new, last_use: r_now};
    end

    always_comb begin
        o_sts.scan_done = r_done;
        o_sts.out_full  = r_ov && !i_out_ready;
        o_sts.cmd_inv   = r_cmd_inv;
        o_sts.hit       = r_hit;
        o_sts.cacheable = r_plain && (r_size != '0) && (r_size <= r_maxf);
        o_sts.fits      = need <= (TOT_W + 1)'(r_budget);
        o_sts.free      = r_free;
        o_sts.lru       = r_lru;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl    <= TTL_DEF;
            r_budget <= BUDGET_DEF;
            r_maxf   <= MAXF_DEF;
            r_valid  <= '0;
            r_busy   <= 1'b0;
            r_ph     <= 1'b0;
            r_done   <= 1'b0;
            r_ctr    <= '0;
            r_mode   <= MODE_INV;
            r_hit    <= 1'b0;
            r_lru    <= 1'b0;
            r_free   <= 1'b0;
            r_total  <= '0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TTL:    r_ttl    <= i_cfg_data;
                    CFG_BUDGET: r_budget <= i_cfg_data;
                    CFG_MAXF:   r_maxf   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_ph   <= r_busy;
            r_done <= r_ph && (r_ph_idx == LAST);
            if (i_cmd.scan_start) begin
                r_busy <= 1'b1;
                r_ctr  <= '0;
                r_mode <= i_cmd.scan_mode;
                r_hit  <= 1'b0;
                r_lru  <= 1'b0;
                r_free <= 1'b0;
                if (i_cmd.scan_mode == MODE_INV) begin
                    r_total <= '0;
                end
            end else if (r_busy) begin
                r_ctr <= r_ctr + CW'(1);
                if (r_ctr == CLAST) begin
                    r_busy <= 1'b0;
                end
            end
            if (hit_take) begin
                r_hit <= 1'b1;
            end
            if (lru_take) begin
                r_lru <= 1'b1;
            end
            if (free_take) begin
                r_free <= 1'b1;
            end
            if (drop_en) begin
                r_valid[drop_idx] <= 1'b0;
                r_total <= tot_sub;
                if (r_cnt != CNT_MAX) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.fill) begin
                r_valid[tgt] <= 1'b1;
                r_total <= r_total + TOT_W'(r_size);
            end
            if (i_cmd.load_in) begin
                r_cnt <= '0;
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd_inv <= i_in_cmd;
            r_now     <= i_in_now;
            r_vol     <= i_in_vol;
            r_ino     <= i_in_ino;
            r_size    <= i_in_size;
            r_plain   <= i_in_plain;
        end
        r_ph_idx <= rd_idx;
        r_q      <= r_mem[rd_idx];
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (hit_take) begin
            r_hit_idx <= r_ph_idx;
        end
        if (lru_take) begin
            r_lru_idx  <= r_ph_idx;
            r_lru_last <= r_q.last_use;
            r_lru_size <= r_q.size;
        end
        if (free_take) begin
            r_free_idx <= r_ph_idx;
        end
        if (i_cmd.load_out) begin
            r_oc <= i_cmd.out_code;
            r_os <= 4'({{4{1'b0}}, out_idx});
            r_oe <= r_cnt;
            r_ob <= r_total[31:0];
        end
    end

    assign o_out_valid = r_ov;
    assign o_outcome   = r_oc;
    assign o_slot      = r_os;
    assign o_evicted   = r_oe;
    assign o_cached    = r_ob;

    `FC_ASSERT(a_cnt_mono, i_clk, i_rst_n, !i_cmd.load_in |=> r_cnt >= $past(r_cnt), "drop count fell within an item")
    `FC_ASSERT(a_fill_free, i_clk, i_rst_n, i_cmd.fill |-> !r_valid[tgt], "fill targets a live slot")
    `FC_ASSERT(a_drop_live, i_clk, i_rst_n, (drop_en && !r_cmd_inv) |-> r_valid[drop_idx], "drop of a dead slot")
    `FC_ASSERT(a_fill_budget, i_clk, i_rst_n, i_cmd.fill |=> r_total <= TOT_W'(r_budget), "fill overran the byte budget")
    `FC_ASSERT_NEVER(a_two_writers, i_clk, i_rst_n, i_cmd.hit_write && i_cmd.fill, "hit update and fill together")

endmodule

### rtl/core/fcache_ctrl.sv
// Sequencer of the file cache metadata core: orders scans, evictions, fills and results.
// Depends on fcache_pkg.
module fcache_ctrl
    import fcache_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LRUGO = 3'd3;
    localparam logic [2:0] S_LRUW  = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_oc, n_oc;

    always_comb begin
        n_state = r_state;
        n_oc    = r_oc;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode  = i_sts.cmd_inv ? MODE_INV : MODE_EXP;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                    if (i_sts.cmd_inv) begin
                        n_oc = OC_INV;
                    end else if (i_sts.hit) begin
                        o_cmd.hit_write = 1'b1;
                        n_oc = OC_HIT;
                    end else if (!i_sts.cacheable) begin
                        n_oc = OC_BYPASS;
                    end else begin
                        n_state = S_LRUGO;
                    end
                end
            end
            S_LRUGO: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode  = MODE_LRU;
                n_state = S_LRUW;
            end
            S_LRUW: begin
                if (i_sts.scan_done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                // evict one LRU entry per scan until the budget fits, then fill; bypass if none is left
                if (!i_sts.fits) begin
                    if (i_sts.lru) begin
                        o_cmd.drop_lru = 1'b1;
                        n_state = S_LRUGO;
                    end else begin
                        n_oc = OC_BYPASS;
                        n_state = S_FIN;
                    end
                end else if (i_sts.free || !i_sts.lru) begin
                    o_cmd.fill = 1'b1;
                    n_oc = OC_FILL;
                    n_state = S_FIN;
                end else begin
                    o_cmd.drop_lru = 1'b1;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_oc = OC_FILL;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.out_code = r_oc;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oc    <= OC_HIT;
        end else begin
            r_state <= n_state;
            r_oc    <= n_oc;
        end
    end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the whole-file cache metadata core.
// Depends on fcache_pkg and file_cache_ttl_lru_budget_core.
module testbench;
    import fcache_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT      = 16;
    localparam int STALL_MAX  = 6000;   // cycles without any transfer
    localparam int HOLD_LONG  = 600;    // long receiver hold-off
    localparam int TAIL_WAIT  = 80;     // a few passes over the slots

    // Input commands, carried on tuser.
    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_INV  = 1'b1;

    typedef struct packed {
        logic [1:0]        outcome;
        logic [3:0]        slot;
        logic [CNT_W-1:0]  evicted;
        logic [31:0]       cached;
    } access_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [151:0]       s_tdata = '0;
    logic [0:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    file_cache_ttl_lru_budget_core #(.SLOTS(NSLOT)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the cache state and registers.
    logic [31:0]        sh_ttl;
    logic [31:0]        sh_budget;
    logic [31:0]        sh_maxfile;
    logic               sh_valid [NSLOT];
    logic [VOL_W-1:0]   sh_volume [NSLOT];
    logic [INO_W-1:0]   sh_inode [NSLOT];
    logic [SIZE_W-1:0]  sh_size [NSLOT];
    logic [EXP_W-1:0]   sh_expiry [NSLOT];
    logic [NOW_W-1:0]   sh_last_use [NSLOT];
    logic [TOT_W-1:0]   sh_total;
    int                 drop_tally;

    access_result_t     pending_results [$];
    int                 fail_count = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_idle_pct = 0;
    int                 hold_off_left = 0;

    // Key pool so that random reads hit, refresh and evict real entries.
    logic [VOL_W-1:0]   pool_vol [12];
    logic [INO_W-1:0]   pool_ino [12];
    logic [SIZE_W-1:0]  pool_size [12];
    logic [NOW_W-1:0]   clock_ms = '0;

    function automatic void drop_entry(int i);
        if (sh_total >= {1'b0, sh_size[i]}) sh_total -= {1'b0, sh_size[i]};
        else sh_total = '0;
        sh_valid[i] = 1'b0;
        if (drop_tally < 31) drop_tally++;
    endfunction

    // Oldest valid entry, lowest index on a tie; NSLOT when none is valid.
    function automatic int oldest_entry();
        int pick;
        pick = NSLOT;
        for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && (pick == NSLOT || sh_last_use[i] < sh_last_use[pick]))
                pick = i;
        return pick;
    endfunction

    function automatic access_result_t cache_access(logic cmd, logic [NOW_W-1:0] now,
            logic [VOL_W-1:0] vol, logic [INO_W-1:0] ino, logic [SIZE_W-1:0] size,
            logic plain);
        access_result_t r;
        logic [EXP_W-1:0] new_exp;
        int hit;
        int free_idx;
        int victim;
        new_exp = {1'b0, now} + {17'd0, sh_ttl};
        drop_tally = 0;
        r = '0;
        if (cmd == CMD_INV) begin
            for (int i = 0; i < NSLOT; i++)
                if (sh_valid[i]) drop_entry(i);
            sh_total = '0;
            r.outcome = OC_INV;
        end else begin
            hit = NSLOT;
            for (int i = 0; i < NSLOT; i++)
                if (sh_valid[i] && sh_expiry[i] <= {1'b0, now}) drop_entry(i);
            for (int i = 0; i < NSLOT; i++)
                if (hit == NSLOT && sh_valid[i] && sh_volume[i] == vol &&
                    sh_inode[i] == ino && sh_size[i] == size)
                    hit = i;
            if (hit < NSLOT) begin
                sh_last_use[hit] = now;
                sh_expiry[hit] = new_exp;
                r.outcome = OC_HIT;
                r.slot = hit[3:0];
            end else if (!plain || size == 0 || size > sh_maxfile) begin
                r.outcome = OC_BYPASS;
            end else begin
                // Evict oldest entries until the budget has room.
                while (sh_total + {1'b0, size} > {1'b0, sh_budget}) begin
                    victim = oldest_entry();
                    if (victim == NSLOT) break;
                    drop_entry(victim);
                end
                if (sh_total + {1'b0, size} > {1'b0, sh_budget}) begin
                    r.outcome = OC_BYPASS;
                end else begin
                    free_idx = NSLOT;
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!sh_valid[i]) free_idx = i;
                    if (free_idx == NSLOT) begin
                        free_idx = oldest_entry();
                        drop_entry(free_idx);
                    end
                    sh_valid[free_idx]    = 1'b1;
                    sh_volume[free_idx]   = vol;
                    sh_inode[free_idx]    = ino;
                    sh_size[free_idx]     = size;
                    sh_expiry[free_idx]   = new_exp;
                    sh_last_use[free_idx] = now;
                    sh_total += {1'b0, size};
                    r.outcome = OC_FILL;
                    r.slot = free_idx[3:0];
                end
            end
        end
        r.evicted = drop_tally[CNT_W-1:0];
        r.cached = sh_total[31:0];
        return r;
    endfunction

    // Offer one access; the predictor runs at the accepting edge.
    task automatic send_access(logic cmd, logic [NOW_W-1:0] now, logic [VOL_W-1:0] vol,
            logic [INO_W-1:0] ino, logic [SIZE_W-1:0] size, logic plain);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, plain, size, ino, vol, now};
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(cache_access(cmd, now, vol, ino, size, plain));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TTL:    sh_ttl = value;
            CFG_BUDGET: sh_budget = value;
            default:    sh_maxfile = value;
        endcase
    endtask

    task automatic refill_pool(int max_size);
        for (int k = 0; k < 12; k++) begin
            pool_vol[k]  = 5'($urandom_range(25));
            pool_ino[k]  = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(40));
            pool_size[k] = $urandom_range(max_size, 1);
        end
    endtask

    // Mostly reads of pooled keys with time moving forward; the rest is noise.
    task automatic send_random_access(int max_size, int max_step);
        int pick;
        int k;
        logic [SIZE_W-1:0] size;
        pick = $urandom_range(99);
        k = $urandom_range(11);
        if (pick < 5) clock_ms = 48'({$urandom, $urandom});
        else clock_ms = clock_ms + 48'($urandom_range(max_step));
        if (pick < 9) begin
            send_access(CMD_INV, clock_ms, 5'($urandom), {$urandom, $urandom}, $urandom, 1'($urandom));
        end else if (pick < 25) begin
            size = ($urandom_range(4) == 0) ? $urandom : $urandom_range(max_size);
            send_access(CMD_READ, clock_ms, 5'($urandom_range(25)), {$urandom, $urandom},
                        size, 1'($urandom));
        end else begin
            send_access(CMD_READ, clock_ms, pool_vol[k], pool_ino[k], pool_size[k],
                        $urandom_range(19) != 0);
        end
    endtask

    task automatic test_defaults_and_fill();
        clock_ms = 48'd1000;
        send_access(CMD_READ, clock_ms, 5'd0, 64'd0, 32'd0, 1'b1);            // zero size
        send_access(CMD_READ, clock_ms, 5'd25, '1, 32'd4194304, 1'b1);        // largest allowed
        send_access(CMD_READ, clock_ms, 5'd25, '1, 32'd4194305, 1'b1);        // one over limit
        send_access(CMD_READ, clock_ms, 5'd3, 64'd7, 32'd100, 1'b0);          // not a plain file
        send_access(CMD_READ, clock_ms, 5'd3, 64'd7, 32'd100, 1'b1);          // fill
        send_access(CMD_READ, clock_ms + 5, 5'd3, 64'd7, 32'd100, 1'b0);      // hit, plain ignored
        send_access(CMD_READ, clock_ms + 6, 5'd31, 64'd7, 32'd100, 1'b1);     // other volume
        send_access(CMD_INV, clock_ms, '1, '1, '1, 1'b1);
        send_access(CMD_INV, '1, '0, '0, '0, 1'b0);                           // empty invalidate
    endtask

    task automatic test_expiry_and_slots();
        write_reg(CFG_TTL, 32'd0);
        send_access(CMD_READ, 48'd50, 5'd1, 64'd1, 32'd10, 1'b1);             // expires at once
        send_access(CMD_READ, 48'd50, 5'd1, 64'd1, 32'd10, 1'b1);             // swept, refilled
        write_reg(CFG_TTL, 32'hFFFF_FFFF);
        // Seventeen distinct files: the last one evicts the oldest when all slots are full.
        for (int i = 0; i < 17; i++)
            send_access(CMD_READ, 48'(100 + (i % 3)), 5'(i % 26), 64'(i + 1000), 32'd8, 1'b1);
        send_access(CMD_READ, '1, 5'd2, 64'd1, 32'd1, 1'b1);                  // now at its top
    endtask

    task automatic test_budget_limits();
        write_reg(CFG_BUDGET, 32'd300);
        send_access(CMD_READ, 48'd500, 5'd4, 64'd1, 32'd200, 1'b1);
        send_access(CMD_READ, 48'd501, 5'd4, 64'd2, 32'd200, 1'b1);          // evicts one
        send_access(CMD_READ, 48'd502, 5'd4, 64'd3, 32'd301, 1'b1);          // never fits
        write_reg(CFG_BUDGET, 32'd0);
        send_access(CMD_READ, 48'd503, 5'd4, 64'd3, 32'd1, 1'b1);
        write_reg(CFG_MAXF, 32'd0);
        write_reg(CFG_BUDGET, 32'hFFFF_FFFF);
        send_access(CMD_READ, 48'd504, 5'd4, 64'd4, 32'd1, 1'b1);
        write_reg(CFG_MAXF, 32'hFFFF_FFFF);
        send_access(CMD_READ, 48'd505, 5'd9, 64'd4, 32'hFFFF_FFFF, 1'b1);
        send_access(CMD_READ, 48'd506, 5'd9, 64'd5, 32'hFFFF_FFFF, 1'b1);    // evicts the big one
    endtask

    task automatic test_random_phase(int s_idle, int r_idle, int items, logic [31:0] ttl,
            logic [31:0] budget, int max_size, int max_step);
        write_reg(CFG_TTL, ttl);
        write_reg(CFG_BUDGET, budget);
        write_reg(CFG_MAXF, 32'(max_size - max_size / 8));
        sender_idle_pct   = s_idle;
        receiver_idle_pct = r_idle;
        refill_pool(max_size);
        for (int n = 0; n < items; n++) send_random_access(max_size, max_step);
    endtask

    task automatic test_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_left = HOLD_LONG;
        for (int n = 0; n < 12; n++) send_random_access(500, 40);
        // Pause until every outstanding result is back, then resume.
        wait_drained();
        for (int n = 0; n < 12; n++) send_random_access(500, 40);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= i_rst_n && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        access_result_t want;
        access_result_t got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[1:0], m_tdata[5:2], m_tdata[10:6], m_tdata[42:11]};
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
                    fail_count++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, got.slot);
                    fail_count++;
                end
                if (got.evicted !== want.evicted) begin
                    $error("evicted_count: expected %0d, got %0d", want.evicted, got.evicted);
                    fail_count++;
                end
                if (got.cached !== want.cached) begin
                    $error("cached_bytes: expected %0d, got %0d", want.cached, got.cached);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles where no channel moves a transfer.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        sh_ttl = TTL_DEF;
        sh_budget = BUDGET_DEF;
        sh_maxfile = MAXF_DEF;
        sh_total = '0;
        for (int i = 0; i < NSLOT; i++) sh_valid[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults_and_fill();
        test_expiry_and_slots();
        test_budget_limits();
        test_random_phase(38, 78, 115, 32'd200, 32'd1200, 400, 30);
        test_random_phase(78, 38, 115, 32'd60, 32'd5000, 900, 12);
        test_random_phase(0, 0, 115, 32'hFFFF_FFFF, 32'd700, 300, 1000);
        test_backpressure();

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
